### hw/rtl/gdpfe_pkg.sv
// ----------------------------------------------------------------------------
// gdpfe_pkg
// Shared register indexes, frame layout and fixed frame bytes for the drift
// position frame encoder.
// ----------------------------------------------------------------------------
package gdpfe_pkg;

   // configuration register indexes
   localparam logic [2:0] CSR_GAIN      = 3'd0;
   localparam logic [2:0] CSR_BASE_LAT  = 3'd1;
   localparam logic [2:0] CSR_BASE_LON  = 3'd2;
   localparam logic [2:0] CSR_BASE_ALT  = 3'd3;
   localparam logic [2:0] CSR_LAT_SCALE = 3'd4;
   localparam logic [2:0] CSR_LON_SCALE = 3'd5;

   // frame layout, byte positions within the 56-byte frame
   localparam int unsigned FRAME_LEN = 56;
   localparam logic [5:0] IDX_CK_FIRST  = 6'd2;
   localparam logic [5:0] IDX_CK_LAST   = 6'd53;
   localparam logic [5:0] IDX_LON       = 6'd30;
   localparam logic [5:0] IDX_LAT       = 6'd34;
   localparam logic [5:0] IDX_HEIGHT    = 6'd38;
   localparam logic [5:0] IDX_HMSL      = 6'd42;
   localparam logic [5:0] IDX_HMSL_END  = 6'd45;
   localparam logic [5:0] IDX_CK_A      = 6'd54;
   localparam logic [5:0] IDX_CK_B      = 6'd55;

   localparam logic [7:0] SYNC_1    = 8'hB5;
   localparam logic [7:0] SYNC_2    = 8'h62;
   localparam logic [7:0] MSG_CLASS = 8'h01;
   localparam logic [7:0] MSG_ID    = 8'h07;
   localparam logic [7:0] PLD_LEN   = 8'd48;

   // fixed frame bytes; position-dependent slots read as zero here
   function automatic logic [7:0] frame_const(input logic [5:0] idx);
      logic [7:0] b;
      b = 8'h00;
      case (idx)
         6'd0:    b = SYNC_1;
         6'd1:    b = SYNC_2;
         6'd2:    b = MSG_CLASS;
         6'd3:    b = MSG_ID;
         6'd4:    b = PLD_LEN;
         6'd6:    b = 8'hE8;   // iTOW = 1000
         6'd7:    b = 8'h03;
         6'd10:   b = 8'hE8;   // year = 2024
         6'd11:   b = 8'h07;
         6'd12:   b = 8'd1;    // month
         6'd13:   b = 8'd1;    // day
         6'd14:   b = 8'd12;   // hour
         6'd17:   b = 8'h04;   // valid
         6'd26:   b = 8'd3;    // fixType
         6'd27:   b = 8'h01;   // flags
         6'd29:   b = 8'd10;   // numSV
         6'd46:   b = 8'hE8;   // hAcc = 1000
         6'd47:   b = 8'h03;
         6'd50:   b = 8'hE8;   // vAcc = 1000
         6'd51:   b = 8'h03;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

### hw/rtl/gps_drift_position_frame_encoder.sv
// ----------------------------------------------------------------------------
// gps_drift_position_frame_encoder
// Drift-adjusted position to geodetic coordinates, framed as a NAV-PVT
// message with running Fletcher-8 checksum, one byte per beat.
// ----------------------------------------------------------------------------
// A position beat can enter on every cycle that the pipeline is not stalled by
// the output into a five-stage arithmetic pipeline (difference, gain multiply,
// round and clamp, scale multiply, round/offset/saturate). Each item leaves as
// 56 byte beats on rsp, so the byte serializer on the output sets the sustained
// rate; an accepted item passes the stage registers s1 to s5 and is then loaded
// into the serializer, which puts its first byte on rsp. The checksum is
// accumulated as bytes go out. Config writes are always taken and must happen
// while idle.
module gps_drift_position_frame_encoder (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // pos_x_mm, pos_y_mm, pos_z_mm, goal_x_mm, goal_y_mm, goal_z_mm (lowest first)
   input  logic [191:0] req_tdata,
   // drift_enable
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // frame_byte
   output logic [7:0]   rsp_tdata,
   output logic         rsp_tlast,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_data
);

   localparam logic signed [36:0] FAKE_HI = 37'sd2147483647;
   localparam logic signed [36:0] FAKE_LO = -37'sd2147483647;
   localparam logic signed [34:0] RES_HI  = 35'sd2147483647;
   localparam logic signed [34:0] RES_LO  = -35'sd2147483648;

   function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
      logic signed [31:0] r;
      if (v > RES_HI)      r = 32'sh7FFF_FFFF;
      else if (v < RES_LO) r = 32'sh8000_0000;
      else                 r = v[31:0];
      return r;
   endfunction

   // ---------------- configuration ----------------
   logic [17:0]        gain_ff;
   logic signed [30:0] base_lat_ff;
   logic signed [31:0] base_lon_ff;
   logic signed [31:0] base_alt_ff;
   logic [31:0]        lat_scale_ff;
   logic [31:0]        lon_scale_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff      <= 18'd32768;
         base_lat_ff  <= 31'sd557558000;
         base_lon_ff  <= 32'sd376173000;
         base_alt_ff  <= 32'sd150000;
         lat_scale_ff <= 32'd385821712;
         lon_scale_ff <= 32'd685540000;
      end else if (csr_valid) begin
         unique case (csr_index)
            gdpfe_pkg::CSR_GAIN:      gain_ff      <= csr_data[17:0];
            gdpfe_pkg::CSR_BASE_LAT:  base_lat_ff  <= csr_data[30:0];
            gdpfe_pkg::CSR_BASE_LON:  base_lon_ff  <= csr_data;
            gdpfe_pkg::CSR_BASE_ALT:  base_alt_ff  <= csr_data;
            gdpfe_pkg::CSR_LAT_SCALE: lat_scale_ff <= csr_data;
            gdpfe_pkg::CSR_LON_SCALE: lon_scale_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // ---------------- pipeline flow control ----------------
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff;
   logic s1_ready, s2_ready, s3_ready, s4_ready, s5_ready, ser_ready;

   assign s5_ready   = !s5_valid_ff || ser_ready;
   assign s4_ready   = !s4_valid_ff || s5_ready;
   assign s3_ready   = !s3_valid_ff || s4_ready;
   assign s2_ready   = !s2_valid_ff || s3_ready;
   assign s1_ready   = !s1_valid_ff || s2_ready;
   assign req_tready = s1_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) s1_valid_ff <= req_tvalid;
         if (s2_ready) s2_valid_ff <= s1_valid_ff;
         if (s3_ready) s3_valid_ff <= s2_valid_ff;
         if (s4_ready) s4_valid_ff <= s3_valid_ff;
         if (s5_ready) s5_valid_ff <= s4_valid_ff;
      end
   end

   // ---------------- stage 1: goal minus position ----------------
   logic signed [31:0] s1_pos_ff  [3];
   logic signed [32:0] s1_diff_ff [3];
   logic signed [32:0] s1_diff_in [3];
   logic               s1_drift_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s1_diff_in[i] = $signed({req_tdata[96+32*i+31], req_tdata[96+32*i +: 32]})
                       - $signed({req_tdata[32*i+31], req_tdata[32*i +: 32]});
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && req_tvalid) begin
         for (int i = 0; i < 3; i++) begin
            s1_pos_ff[i]  <= req_tdata[32*i +: 32];
            s1_diff_ff[i] <= s1_diff_in[i];
         end
         s1_drift_ff <= req_tuser;
      end
   end

   // ---------------- stage 2: gain multiply ----------------
   logic signed [31:0] s2_pos_ff  [3];
   logic signed [51:0] s2_prod_ff [3];
   logic signed [51:0] s2_prod_in [3];
   logic               s2_drift_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s2_prod_in[i] = $signed({1'b0, gain_ff}) * s1_diff_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready && s1_valid_ff) begin
         s2_pos_ff   <= s1_pos_ff;
         s2_prod_ff  <= s2_prod_in;
         s2_drift_ff <= s1_drift_ff;
      end
   end

   // ---------------- stage 3: round, subtract if drift enabled, clamp ----------------
   logic signed [31:0] s3_fake_ff [3];
   logic signed [31:0] s3_fake_in [3];
   logic signed [51:0] s3_rnd     [3];
   logic signed [36:0] s3_wide    [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s3_rnd[i] = s2_prod_ff[i] + 52'sd32768;
         if (s2_drift_ff) begin
            s3_wide[i] = $signed({{5{s2_pos_ff[i][31]}}, s2_pos_ff[i]})
                       - $signed({s3_rnd[i][51], s3_rnd[i][51:16]});
         end else begin
            s3_wide[i] = $signed({{5{s2_pos_ff[i][31]}}, s2_pos_ff[i]});
         end
         if (s3_wide[i] > FAKE_HI)      s3_fake_in[i] = FAKE_HI[31:0];
         else if (s3_wide[i] < FAKE_LO) s3_fake_in[i] = FAKE_LO[31:0];
         else                           s3_fake_in[i] = s3_wide[i][31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (s3_ready && s2_valid_ff) s3_fake_ff <= s3_fake_in;
   end

   // ---------------- stage 4: scale multiply, altitude ----------------
   logic signed [65:0] s4_lat_prod_ff, s4_lon_prod_ff;
   logic signed [33:0] s4_alt_ff;
   logic signed [32:0] s4_neg_y;

   // y is southward positive, so north is minus y
   assign s4_neg_y = 33'sd0 - $signed({s3_fake_ff[1][31], s3_fake_ff[1]});

   always_ff @(posedge clock) begin
      if (s4_ready && s3_valid_ff) begin
         s4_lat_prod_ff <= s4_neg_y * $signed({1'b0, lat_scale_ff});
         s4_lon_prod_ff <= $signed({s3_fake_ff[0][31], s3_fake_ff[0]})
                         * $signed({1'b0, lon_scale_ff});
         s4_alt_ff      <= $signed({{2{base_alt_ff[31]}}, base_alt_ff})
                         - $signed({{2{s3_fake_ff[2][31]}}, s3_fake_ff[2]});
      end
   end

   // ---------------- stage 5: round, add origin, saturate ----------------
   logic signed [65:0] s5_lat_rnd, s5_lon_rnd;
   logic signed [34:0] s5_lat_sum, s5_lon_sum;
   logic signed [31:0] s5_lat_ff, s5_lon_ff, s5_alt_ff;

   assign s5_lat_rnd = s4_lat_prod_ff + 66'sd2147483648;
   assign s5_lon_rnd = s4_lon_prod_ff + 66'sd2147483648;
   assign s5_lat_sum = $signed({{4{base_lat_ff[30]}}, base_lat_ff})
                     + $signed({s5_lat_rnd[65], s5_lat_rnd[65:32]});
   assign s5_lon_sum = $signed({{3{base_lon_ff[31]}}, base_lon_ff})
                     + $signed({s5_lon_rnd[65], s5_lon_rnd[65:32]});

   always_ff @(posedge clock) begin
      if (s5_ready && s4_valid_ff) begin
         s5_lat_ff <= sat32(s5_lat_sum);
         s5_lon_ff <= sat32(s5_lon_sum);
         s5_alt_ff <= sat32($signed({s4_alt_ff[33], s4_alt_ff}));
      end
   end

   // ---------------- byte serializer with running checksum ----------------
   logic        ser_valid_ff, ser_valid_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [7:0]  ck_a_ff, ck_a_in, ck_b_ff, ck_b_in;
   logic [31:0] lat_ff, lon_ff, alt_ff;
   logic [7:0]  byte_out;
   logic [1:0]  byte_sel;
   logic        is_last, fire, load;

   assign is_last   = (cnt_ff == gdpfe_pkg::IDX_CK_B);
   assign fire      = ser_valid_ff && rsp_tready;
   assign ser_ready = !ser_valid_ff || (fire && is_last);
   assign load      = ser_ready && s5_valid_ff;
   // field slots all start on a multiple of four plus two
   assign byte_sel  = cnt_ff[1:0] + 2'd2;

   always_comb begin
      byte_out = gdpfe_pkg::frame_const(cnt_ff);
      if (cnt_ff >= gdpfe_pkg::IDX_LON && cnt_ff < gdpfe_pkg::IDX_LAT)
         byte_out = lon_ff[8*byte_sel +: 8];
      else if (cnt_ff >= gdpfe_pkg::IDX_LAT && cnt_ff < gdpfe_pkg::IDX_HEIGHT)
         byte_out = lat_ff[8*byte_sel +: 8];
      else if (cnt_ff >= gdpfe_pkg::IDX_HEIGHT && cnt_ff <= gdpfe_pkg::IDX_HMSL_END)
         byte_out = alt_ff[8*byte_sel +: 8];
      else if (cnt_ff == gdpfe_pkg::IDX_CK_A)
         byte_out = ck_a_ff;
      else if (cnt_ff == gdpfe_pkg::IDX_CK_B)
         byte_out = ck_b_ff;
   end

   always_comb begin
      ser_valid_in = ser_valid_ff;
      cnt_in       = cnt_ff;
      ck_a_in      = ck_a_ff;
      ck_b_in      = ck_b_ff;
      if (load) begin
         ser_valid_in = 1'b1;
         cnt_in       = 6'd0;
         ck_a_in      = 8'd0;
         ck_b_in      = 8'd0;
      end else if (fire) begin
         if (is_last) ser_valid_in = 1'b0;
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff >= gdpfe_pkg::IDX_CK_FIRST && cnt_ff <= gdpfe_pkg::IDX_CK_LAST) begin
            ck_a_in = ck_a_ff + byte_out;
            ck_b_in = ck_b_ff + ck_a_ff + byte_out;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ser_valid_ff <= 1'b0;
         cnt_ff       <= 6'd0;
      end else begin
         ser_valid_ff <= ser_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      ck_a_ff <= ck_a_in;
      ck_b_ff <= ck_b_in;
      if (load) begin
         lat_ff <= s5_lat_ff;
         lon_ff <= s5_lon_ff;
         alt_ff <= s5_alt_ff;
      end
   end

   assign rsp_tvalid = ser_valid_ff;
   assign rsp_tdata  = byte_out;
   assign rsp_tlast  = is_last;

endmodule

### hw/rtl/gdpfe_checker.sv
// ----------------------------------------------------------------------------
// gdpfe_checker
// Port-level checks on frame framing of the drift position frame encoder.
// ----------------------------------------------------------------------------
module gdpfe_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast
);

   localparam logic [5:0] LAST_BEAT = 6'(gdpfe_pkg::FRAME_LEN - 1);

   logic [5:0] beat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff <= 6'd0;
      end else if (rsp_tvalid && rsp_tready) begin
         beat_ff <= rsp_tlast ? 6'd0 : beat_ff + 6'd1;
      end
   end

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp beat changed while stalled");

   a_last_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> beat_ff == LAST_BEAT)
      else $error("tlast not on the final frame byte");

   a_len: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && beat_ff == LAST_BEAT |-> rsp_tlast)
      else $error("frame longer than expected");

   a_sync: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && beat_ff == 6'd0 |-> rsp_tdata == gdpfe_pkg::SYNC_1)
      else $error("frame does not open with sync byte");

endmodule

bind gps_drift_position_frame_encoder gdpfe_checker u_gdpfe_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
